@@ src/sdf_pkg.sv @@
`default_nettype none
package sdf_pkg;

   localparam int COORD_BITS_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 12;
   localparam int QSH               = 30;

   // Q30 constants
   localparam longint Q_SPH_R    = 64'sd107374182;
   localparam longint Q_HALF_C   = 64'sd80530637;
   localparam longint Q_CONE_N   = 64'sd960383883;
   localparam longint Q_CONE_Z   = 64'sd480191942;
   localparam longint Q_CONE_OFF = 64'sd96038388;
   localparam longint Q_TOR_R    = 64'sd85899346;
   localparam longint Q_TOR_S    = 64'sd42949673;
   localparam longint Q_OCT_S    = 64'sd161061274;
   localparam longint Q_OCT_K    = 64'sd619925132;

   localparam longint RING_X [6] = '{64'sd0, 64'sd278964556, 64'sd278969815,
                                     64'sd10518, -64'sd278959297, -64'sd278975074};
   localparam longint RING_Y [6] = '{64'sd322122547, 64'sd161064310, -64'sd161055201,
                                     -64'sd322122547, -64'sd161073419, 64'sd161046092};

   // Q30 to fraction bits, rounded half away from zero
   function automatic longint to_fix(input longint c, input int fb);
      longint half;
      half = longint'(1) <<< (QSH - fb - 1);
      if (c >= 0) return (c + half) >>> (QSH - fb);
      return -(((-c) + half) >>> (QSH - fb));
   endfunction

endpackage
`default_nettype wire

@@ src/sdf_isqrt.sv @@
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module sdf_isqrt
   import sdf_pkg::*;
#(
   parameter int IN_BITS = 40,
   parameter int TAG_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic [IN_BITS-1:0]  rad_in,
   input  wire logic [TAG_BITS-1:0] tag_in,
   output logic [IN_BITS/2-1:0]     root_out,
   output logic [TAG_BITS-1:0]      tag_out
);
   localparam int RB = (IN_BITS + 1) / 2;
   localparam int NB = 2 * RB;

   logic [NB-1:0]       rem_ff  [RB+1];
   logic [RB-1:0]       root_ff [RB+1];
   logic [NB-1:0]       rad_ff  [RB+1];
   logic [TAG_BITS-1:0] tag_ff  [RB+1];

   always_comb begin
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      rad_ff[0]  = NB'(rad_in);
      tag_ff[0]  = tag_in;
   end

   for (genvar s = 0; s < RB; s++) begin : g_stage
      logic [NB+1:0] trial_in;
      logic [NB+1:0] cur_in;
      always_comb begin
         cur_in   = {rem_ff[s], rad_ff[s][NB-1 -: 2]};
         trial_in = {({2'b0, root_ff[s]} << 2) | (NB+2)'(1)};
      end
      // tag carries the valid bit, so it is cleared at reset
      always_ff @(posedge clock) begin
         if (reset) tag_ff[s+1] <= '0;
         else if (en) tag_ff[s+1] <= tag_ff[s];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s+1] <= rad_ff[s] << 2;
            if (cur_in >= trial_in) begin
               rem_ff[s+1]  <= NB'(cur_in - trial_in);
               root_ff[s+1] <= {root_ff[s][RB-2:0], 1'b1};
            end else begin
               rem_ff[s+1]  <= NB'(cur_in);
               root_ff[s+1] <= {root_ff[s][RB-2:0], 1'b0};
            end
         end
      end
   end

   assign root_out = root_ff[RB][IN_BITS/2-1:0];
   assign tag_out  = tag_ff[RB];
endmodule
`default_nettype wire

@@ src/sdf_scene_distance_core.sv @@
`default_nettype none
// Scene distance engine.
// req_valid/req_ready carry one point (req_px, req_py, req_pz) a beat; rsp_valid/rsp_ready
// carry one signed distance a beat, in the same fixed-point format, saturated.
// Every point yields exactly one distance, in order.
// Throughput is one point per cycle while the output is not stalled. The path from an
// accepted point to its distance is 49 register stages at defaults, most of them in
// two bit-per-stage square root pipelines in series (torus needs a root of a root).
// The pipeline advances only while the output register is empty or being
// drained, so req_ready drops in the cycle the receiver stalls with a full output;
// nothing is lost or repeated.
// Reset clears all valid bits; no result is presented until a new point enters.
// The scene: sphere at origin plus cuboid, cone, cylinder, torus, octahedron bound
// and capsule on a ring of radius 0.3; the output is their minimum.
module sdf_scene_distance_core
   import sdf_pkg::*;
#(
   parameter int COORD_BITS    = COORD_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_px,
   input  wire logic signed [COORD_BITS-1:0] req_py,
   input  wire logic signed [COORD_BITS-1:0] req_pz,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0]      rsp_distance
);
   localparam int FB = FRACTION_BITS;
   localparam int W  = COORD_BITS + 3;        // working width of differences
   localparam int SB = 2 * W + 2;             // sum of three squares
   localparam int RW = SB / 2 + 1;            // root width (isqrt out)
   localparam int DW = W + 4;                 // distance working width
   localparam int TW = RW + 2;                // torus inner term width
   localparam int SB2 = 2 * TW + 1;

   localparam logic signed [W-1:0] HC   = W'(to_fix(Q_HALF_C, FB));
   localparam logic signed [W-1:0] SPR  = W'(to_fix(Q_SPH_R, FB));
   localparam logic signed [W-1:0] CONO = W'(to_fix(Q_CONE_OFF, FB));
   localparam logic signed [W-1:0] TORR = W'(to_fix(Q_TOR_R, FB));
   localparam logic signed [W-1:0] TORS = W'(to_fix(Q_TOR_S, FB));
   localparam logic signed [W-1:0] OCTS = W'(to_fix(Q_OCT_S, FB));

   typedef logic signed [W-1:0]  crd_type;
   typedef logic signed [DW-1:0] dst_type;
   typedef logic [SB-1:0]        sq_type;

   // ---- handshake / stall ----
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;

   // ---- stage 1: ring offsets and folded terms ----
   logic    v1_ff;
   crd_type x1_ff, y1_ff, z1_ff;
   crd_type qx_ff [6], qy_ff [6];
   crd_type capdz_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= W'(req_px);
         y1_ff <= W'(req_py);
         z1_ff <= W'(req_pz);
         for (int k = 0; k < 6; k++) begin
            qx_ff[k] <= W'(req_px) - W'(to_fix(RING_X[k], FB));
            qy_ff[k] <= W'(req_py) - W'(to_fix(RING_Y[k], FB));
         end
         if (W'(req_pz) > HC)       capdz_ff <= W'(req_pz) - HC;
         else if (W'(req_pz) < -HC) capdz_ff <= W'(req_pz) + HC;
         else                       capdz_ff <= '0;
      end
   end

   // ---- stage 2: absolute terms and squares ----
   function automatic sq_type sqr(input crd_type v);
      logic [W-1:0] m;
      m = v[W-1] ? W'(-v) : W'(v);
      return SB'(m) * SB'(m);
   endfunction
   function automatic crd_type mx0(input crd_type v);
      return v[W-1] ? '0 : v;
   endfunction
   function automatic crd_type ab(input crd_type v);
      return v[W-1] ? -v : v;
   endfunction

   logic    v2_ff;
   sq_type  s_sph_ff, s_cub_ff, s_cone_ff, s_cyl_ff, s_tor_ff, s_cap_ff;
   sq_type  s_z2_ff;
   crd_type z2_ff, cubmx_ff, octt_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      crd_type dx, dy, dz, m;
      if (en) begin
         dx = ab(qx_ff[0]) - HC;
         dy = ab(qy_ff[0]) - HC;
         dz = ab(z1_ff) - HC;
         m  = (dx > dy) ? dx : dy;
         m  = (m > dz) ? m : dz;
         cubmx_ff  <= m[W-1] ? m : '0;
         s_sph_ff  <= sqr(x1_ff) + sqr(y1_ff) + sqr(z1_ff);
         s_cub_ff  <= sqr(mx0(dx)) + sqr(mx0(dy)) + sqr(mx0(dz));
         s_cone_ff <= sqr(qx_ff[1]) + sqr(qy_ff[1]);
         s_cyl_ff  <= sqr(qx_ff[2]) + sqr(qy_ff[2]);
         s_tor_ff  <= sqr(qx_ff[3]) + sqr(qy_ff[3]);
         s_cap_ff  <= sqr(qx_ff[5]) + sqr(qy_ff[5]) + sqr(capdz_ff);
         s_z2_ff   <= sqr(z1_ff);
         z2_ff     <= z1_ff;
         octt_ff   <= ab(qx_ff[4]) + ab(qy_ff[4]) + ab(z1_ff) - OCTS;
      end
   end

   // ---- stage 3..: six roots in parallel; side terms ride on the tag ----
   localparam int TAGB = 1 + W + W + W + SB;
   logic [TAGB-1:0] tag_in_w, tag_out_w;
   logic [RW-1:0]   r_sph, r_cub, r_cone, r_cyl, r_tor, r_cap;
   logic [4:0]      v_sq;

   assign tag_in_w = {v2_ff, z2_ff, cubmx_ff, octt_ff, s_z2_ff};

   sdf_isqrt #(.IN_BITS(SB), .TAG_BITS(TAGB)) u_sq_sph (
      .clock, .reset, .en, .rad_in(s_sph_ff), .tag_in(tag_in_w),
      .root_out(r_sph[RW-2:0]), .tag_out(tag_out_w));
   assign r_sph[RW-1] = 1'b0;

   for (genvar i = 0; i < 5; i++) begin : g_sq
      sq_type        rad_w;
      logic [RW-2:0] rt_w;
      logic          tg_w;
      always_comb begin
         case (i)
            0: rad_w = s_cub_ff;
            1: rad_w = s_cone_ff;
            2: rad_w = s_cyl_ff;
            3: rad_w = s_tor_ff;
            default: rad_w = s_cap_ff;
         endcase
      end
      sdf_isqrt #(.IN_BITS(SB), .TAG_BITS(1)) u_sq (
         .clock, .reset, .en, .rad_in(rad_w), .tag_in(v2_ff),
         .root_out(rt_w), .tag_out(tg_w));
      assign v_sq[i] = tg_w;
      case (i)
         0: begin : g0 assign r_cub  = {1'b0, rt_w}; end
         1: begin : g1 assign r_cone = {1'b0, rt_w}; end
         2: begin : g2 assign r_cyl  = {1'b0, rt_w}; end
         3: begin : g3 assign r_tor  = {1'b0, rt_w}; end
         default: begin : g4 assign r_cap = {1'b0, rt_w}; end
      endcase
   end

   logic          v3, v3_sph;
   crd_type       z3, cubmx3, octt3;
   sq_type        sz3;
   assign {v3_sph, z3, cubmx3, octt3, sz3} = tag_out_w;
   // every root lane carries its own copy of the valid bit
   assign v3 = v3_sph & (&v_sq);

   // ---- stage A: partial distances, cone/oct products, torus term ----
   localparam int PW = DW + 32;
   logic          va_ff;
   dst_type       d_sph_a, d_cub_a, d_cyl_a, d_cap_a, rho_a, nz_a;
   logic signed [PW-1:0] p_cn_a, p_cz_a, p_oc_a;
   logic [SB2-1:0] s_tor2_a;

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (en) va_ff <= v3;
   end

   always_ff @(posedge clock) begin
      dst_type cyl_r, cyl_z, tt;
      logic [TW-1:0] tm;
      if (en) begin
         d_sph_a <= DW'(r_sph) - DW'(SPR);
         d_cub_a <= DW'(r_cub) + DW'(cubmx3);
         cyl_r    = DW'(r_cyl) - DW'(SPR);
         cyl_z    = DW'(ab(z3)) - DW'(SPR);
         d_cyl_a <= (cyl_r > cyl_z) ? cyl_r : cyl_z;
         d_cap_a <= DW'(r_cap) - DW'(HC);
         rho_a   <= DW'(r_cone);
         nz_a    <= -DW'(z3);
         p_cn_a  <= PW'(DW'(r_cone)) * PW'(Q_CONE_N);
         p_cz_a  <= PW'(z3) * PW'(Q_CONE_Z);
         p_oc_a  <= PW'(octt3) * PW'(Q_OCT_K);
         tt       = DW'(TORR) - DW'(r_tor);
         tm       = tt[DW-1] ? TW'(-tt) : TW'(tt);
         s_tor2_a <= SB2'(SB2'(tm) * SB2'(tm)) + SB2'(sz3);
      end
   end

   // round_q30: floor((v + 2^29) / 2^30)
   function automatic dst_type rq(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] w;
      w = v + (PW'(1) <<< (QSH - 1));
      return DW'(w >>> QSH);
   endfunction

   // ---- stage B: cone and octahedron finished, min of early ones ----
   logic    vb_ff;
   dst_type m_b;
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (en) vb_ff <= va_ff;
   end
   always_ff @(posedge clock) begin
      dst_type t, c, o, m;
      if (en) begin
         t = rq(p_cn_a + p_cz_a) - DW'(CONO);
         c = (-rho_a > nz_a) ? -rho_a : nz_a;
         c = (c > t) ? c : t;
         o = rq(p_oc_a);
         m = (d_sph_a < d_cub_a) ? d_sph_a : d_cub_a;
         m = (m < c) ? m : c;
         m = (m < d_cyl_a) ? m : d_cyl_a;
         m = (m < o) ? m : o;
         m = (m < d_cap_a) ? m : d_cap_a;
         m_b <= m;
      end
   end

   // ---- torus second root ----
   localparam int TAG2 = 1 + DW;
   logic [TW-1:0]   r_t2;
   logic [TAG2-1:0] t2_out;
   logic [SB2-1:0]  s_tor2_b;
   always_ff @(posedge clock) begin
      if (en) s_tor2_b <= s_tor2_a;
   end
   sdf_isqrt #(.IN_BITS(SB2), .TAG_BITS(TAG2)) u_sq_tor2 (
      .clock, .reset, .en, .rad_in(s_tor2_b), .tag_in({vb_ff, m_b}),
      .root_out(r_t2), .tag_out(t2_out));

   // ---- final min and saturation ----
   localparam logic signed [DW-1:0] LO = -(DW'(1) <<< (COORD_BITS - 1));
   localparam logic signed [DW-1:0] HI = (DW'(1) <<< (COORD_BITS - 1)) - DW'(1);
   logic signed [COORD_BITS-1:0] dist_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= t2_out[TAG2-1];
   end
   always_ff @(posedge clock) begin
      dst_type td, m;
      if (en) begin
         td = DW'({1'b0, r_t2}) - DW'(TORS);
         m  = t2_out[DW-1:0];
         m  = (m < td) ? m : td;
         if (m < LO)      dist_ff <= LO[COORD_BITS-1:0];
         else if (m > HI) dist_ff <= HI[COORD_BITS-1:0];
         else             dist_ff <= m[COORD_BITS-1:0];
      end
   end
   assign rsp_distance = dist_ff;

   // ---- checks ----
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("ready low with empty output");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("result changed under stall");
   a_no_accept_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("accepted while stalled");
endmodule
`default_nettype wire
